// File: sv/prta_pkg.sv
`default_nettype none

package prta_pkg;

  // Item field widths
  localparam int BYTE_W = 8;

  // Default table depth
  localparam int TABLE_ENTRIES_DEF = 10;

  // Byte positions of the request header
  localparam int POS_CODE  = 0;
  localparam int POS_BEGIN = 1;
  localparam int POS_SIZE  = 2;
  localparam int HDR_LEN   = 3;

  // Byte counter saturates here
  localparam logic [BYTE_W-1:0] COUNT_MAX = 8'd255;

  // Exception byte: function code with the top bit toggled
  localparam logic [BYTE_W-1:0] EXC_FLAG = 8'h80;

endpackage

`default_nettype wire

// File: sv/prta_if.sv
`default_nettype none

// Request channel: one request byte per item
interface prta_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [prta_pkg::BYTE_W-1:0] pdu_byte;
  logic                        pdu_last;

  modport source (output valid, output req_type, output pdu_byte, output pdu_last,
                  input ready);
  modport sink   (input valid, input req_type, input pdu_byte, input pdu_last,
                  output ready);
endinterface

// Response channel: one response byte per item
interface prta_resp_if;
  logic                        valid;
  logic                        ready;
  logic [prta_pkg::BYTE_W-1:0] resp_byte;
  logic                        resp_last;
  logic                        exception;

  modport source (output valid, output resp_byte, output resp_last, output exception,
                  input ready);
  modport sink   (input valid, input resp_byte, input resp_last, input exception,
                  output ready);
endinterface

`default_nettype wire

// File: sv/pdu_register_table_access_unit.sv
// Register table access unit.
// in_req  : request bytes (function code, begin, size, then write data), req_type
//           taken from the first byte, pdu_last on the final byte. One byte per
//           cycle is taken while a request is being collected.
// out_resp: response bytes with resp_last on the final one. A failed check gives a
//           single byte, code plus 128, with exception set.
// Sequence: request bytes enter while collecting, then a check state runs. A read
// gives 3 header bytes, then table bytes, each through an issue and a wait state
// since the table memory read is registered. A passing write first copies its
// data from the staging memory into the table, each byte through a read and a
// write state, then gives the 3 header bytes. in_req is not ready from the final
// byte until the last response byte is in the output register.
// Reset (rst_n low, synchronous): the table reads back entry i = i through per-entry
// valid bits, the byte counter and header registers clear, no output is pending.
// A stalled receiver holds the output register; the sequencer waits with it.
`default_nettype none

module pdu_register_table_access_unit #(
  parameter int TABLE_ENTRIES = prta_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  prta_req_if.sink    in_req,
  prta_resp_if.source out_resp
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int BW = prta_pkg::BYTE_W;
  localparam logic [BW-1:0] ENTRIES_B = BW'(TABLE_ENTRIES);
  localparam logic [BW-1:0] HDR_LEN_B = BW'(prta_pkg::HDR_LEN);

  typedef enum logic [2:0] {
    S_COLLECT, S_CHECK, S_CP_RD, S_CP_WR, S_HDR, S_RD_ISSUE, S_RD_WAIT, S_EXC
  } state_t;

  state_t        state_r;
  logic [BW-1:0] cnt_r;
  logic [BW-1:0] len_r;
  logic [BW-1:0] code_r;
  logic [BW-1:0] begin_r;
  logic [BW-1:0] size_r;
  logic          kind_r;
  logic [BW-1:0] idx_r;
  logic [1:0]    hidx_r;
  logic [AW-1:0] cp_wa_r;

  logic          out_valid_r;
  logic [BW-1:0] out_byte_r;
  logic          out_last_r;
  logic          out_exc_r;

  // Memories and their read registers
  logic [BW-1:0] tbl_mem_r [TABLE_ENTRIES];
  logic [BW-1:0] wbuf_mem_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] tbl_vld_r;
  logic [BW-1:0] tbl_q_r;
  logic          tbl_hit_r;
  logic [AW-1:0] tbl_ra_r;
  logic [BW-1:0] wbuf_q_r;

  logic          in_acc;
  logic          out_free;
  logic          out_load;
  logic [BW-1:0] cnt_sat;
  logic [BW-1:0] wb_off;
  logic          wb_we;
  logic [AW-1:0] tbl_ra;
  logic          tbl_we;
  logic [BW-1:0] tbl_rdata;
  logic [BW-1:0] idx_inc;
  logic          idx_done;
  logic          ok_len;
  logic          ok_begin;
  logic          ok_range;
  logic          ok_wlen;

  // Handshake
  assign in_req.ready   = (state_r == S_COLLECT);
  assign in_acc         = in_req.valid && in_req.ready;
  assign out_free       = !out_valid_r || out_resp.ready;
  assign out_load       = out_free && ((state_r == S_HDR) || (state_r == S_RD_WAIT) ||
                                       (state_r == S_EXC));
  assign out_resp.valid     = out_valid_r;
  assign out_resp.resp_byte = out_byte_r;
  assign out_resp.resp_last = out_last_r;
  assign out_resp.exception = out_exc_r;

  // Byte position bookkeeping
  assign cnt_sat = (cnt_r == prta_pkg::COUNT_MAX) ? prta_pkg::COUNT_MAX : cnt_r + 8'd1;
  assign wb_off  = cnt_r - HDR_LEN_B;
  assign wb_we   = in_acc && (cnt_r >= HDR_LEN_B) && (wb_off < ENTRIES_B);

  // Table addressing and write-back
  assign tbl_ra    = AW'(begin_r + idx_r);
  assign tbl_we    = (state_r == S_CP_WR);
  assign tbl_rdata = tbl_hit_r ? tbl_q_r : BW'(tbl_ra_r);
  assign idx_inc   = idx_r + 8'd1;
  assign idx_done  = (idx_inc == size_r);

  // Request checks
  assign ok_len   = kind_r ? (len_r >= HDR_LEN_B) : (len_r == HDR_LEN_B);
  assign ok_begin = (begin_r < ENTRIES_B);
  assign ok_range = ({1'b0, begin_r} + {1'b0, size_r}) <= {1'b0, ENTRIES_B};
  assign ok_wlen  = !kind_r || ({1'b0, len_r} == ({1'b0, size_r} + {1'b0, HDR_LEN_B}));

  // Staging memory for write data
  always_ff @(posedge clk) begin
    if (wb_we) begin
      wbuf_mem_r[wb_off[AW-1:0]] <= in_req.pdu_byte;
    end
    wbuf_q_r <= wbuf_mem_r[idx_r[AW-1:0]];
  end

  // Register table memory
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem_r[cp_wa_r] <= wbuf_q_r;
    end
    tbl_q_r  <= tbl_mem_r[tbl_ra];
    tbl_ra_r <= tbl_ra;
  end

  // Written-entry flags; an unwritten entry reads as its own index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
      tbl_hit_r <= 1'b0;
    end else begin
      if (tbl_we) begin
        tbl_vld_r[cp_wa_r] <= 1'b1;
      end
      tbl_hit_r <= tbl_vld_r[tbl_ra];
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_COLLECT;
      cnt_r       <= '0;
      len_r       <= '0;
      code_r      <= '0;
      begin_r     <= '0;
      size_r      <= '0;
      kind_r      <= 1'b0;
      idx_r       <= '0;
      hidx_r      <= '0;
      cp_wa_r     <= '0;
      out_valid_r <= 1'b0;
      out_byte_r  <= '0;
      out_last_r  <= 1'b0;
      out_exc_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_resp.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_COLLECT: begin
          if (in_acc) begin
            if (cnt_r == BW'(prta_pkg::POS_CODE)) begin
              code_r <= in_req.pdu_byte;
              kind_r <= in_req.req_type;
            end else if (cnt_r == BW'(prta_pkg::POS_BEGIN)) begin
              begin_r <= in_req.pdu_byte;
            end else if (cnt_r == BW'(prta_pkg::POS_SIZE)) begin
              size_r <= in_req.pdu_byte;
            end
            if (in_req.pdu_last) begin
              cnt_r   <= '0;
              len_r   <= cnt_sat;
              state_r <= S_CHECK;
            end else begin
              cnt_r <= cnt_sat;
            end
          end
        end
        S_CHECK: begin
          idx_r  <= '0;
          hidx_r <= '0;
          if (!(ok_len && ok_begin && ok_range && ok_wlen)) begin
            state_r <= S_EXC;
          end else if (kind_r && (size_r != '0)) begin
            state_r <= S_CP_RD;
          end else begin
            state_r <= S_HDR;
          end
        end
        S_CP_RD: begin
          // staging read of entry idx is in flight
          cp_wa_r <= tbl_ra;
          state_r <= S_CP_WR;
        end
        S_CP_WR: begin
          if (idx_done) begin
            idx_r   <= '0;
            state_r <= S_HDR;
          end else begin
            idx_r   <= idx_inc;
            state_r <= S_CP_RD;
          end
        end
        S_HDR: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_exc_r   <= 1'b0;
            out_last_r  <= 1'b0;
            hidx_r      <= hidx_r + 2'd1;
            case (hidx_r)
              2'(prta_pkg::POS_CODE):  out_byte_r <= code_r;
              2'(prta_pkg::POS_BEGIN): out_byte_r <= begin_r;
              default: begin
                out_byte_r <= size_r;
                out_last_r <= kind_r || (size_r == '0);
                state_r    <= (kind_r || (size_r == '0)) ? S_COLLECT : S_RD_ISSUE;
              end
            endcase
          end
        end
        S_RD_ISSUE: begin
          state_r <= S_RD_WAIT;
        end
        S_RD_WAIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_byte_r  <= tbl_rdata;
            out_last_r  <= idx_done;
            out_exc_r   <= 1'b0;
            idx_r       <= idx_inc;
            state_r     <= idx_done ? S_COLLECT : S_RD_ISSUE;
          end
        end
        S_EXC: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_byte_r  <= code_r ^ prta_pkg::EXC_FLAG;
            out_last_r  <= 1'b1;
            out_exc_r   <= 1'b1;
            state_r     <= S_COLLECT;
          end
        end
        default: state_r <= S_COLLECT;
      endcase
    end
  end

  // Checks
  a_exc_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_exc_r |-> out_last_r)
    else $error("exception byte without resp_last");

  a_stop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_req.pdu_last |=> !in_req.ready)
    else $error("request taken after final byte");

  a_tbl_wa_range: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> (9'(cp_wa_r) < 9'(TABLE_ENTRIES)))
    else $error("table write beyond last entry");

  a_tbl_write_passed: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> kind_r && ok_len && ok_begin && ok_range && ok_wlen)
    else $error("table written by a failing request");

endmodule

`default_nettype wire
